// ===== sv/dpd_pkg.sv =====
// Package for the delta patch decoder: payload structs, command, status and
// internal operation codes, and the stream magic. No dependencies.
`timescale 1ns / 1ps

package dpd_pkg;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic        is_status;
      logic [7:0]  out_byte;
      logic [2:0]  status;
      logic [31:0] out_count;
   } rsp_type;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_DELTA  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_BAD_VER   = 3'd3;
   localparam logic [2:0] ST_COPY_OOB  = 3'd4;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd5;
   localparam logic [2:0] ST_SIZE      = 3'd6;
   localparam logic [2:0] ST_MISUSE    = 3'd7;

   // Work handed from the parser to the back end, in stream order.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_LITERAL,
      OP_READ,
      OP_STATUS
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [2:0]  status;
      logic [31:0] count;
   } entry_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h44;
         2'd1:    b = 8'h44;
         2'd2:    b = 8'h4C;
         default: b = 8'h54;
      endcase
      return b;
   endfunction

endpackage

// ===== sv/dpd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module dpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dpd_queue.sv =====
// Four-entry first-in first-out queue between the parser and the back end.
// Generic over its data width; no dependencies.
`timescale 1ns / 1ps

module dpd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/dpd_front.sv =====
// Front end of the delta patch decoder: accepts transactions, parses the delta
// stream and queues memory writes, literal bytes, copy reads and status.
// Depends on dpd_pkg.
`timescale 1ns / 1ps

module dpd_front
   import dpd_pkg::*;
#(
   parameter int BASE_DEPTH = 65536,
   parameter int ADDR_W     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  req_type           item,
   input  logic              csr_write,
   input  logic [16:0]       csr_data,
   output logic              push,
   output entry_type         push_entry,
   output logic [ADDR_W-1:0] push_addr
);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_VERSION,
      PH_TSIZE,
      PH_TYPE,
      PH_LENGTH,
      PH_OFFSET,
      PH_INSERT,
      PH_DRAIN
   } phase_type;

   localparam logic [32:0] COUNT_MAX = 33'h1_FFFF_FFFF;
   localparam logic [32:0] DEPTH_33  = 33'(BASE_DEPTH);
   localparam int          XW        = (ADDR_W > 16) ? ADDR_W : 16;

   phase_type         phase_ff, phase_in;
   logic [1:0]        fbytes_ff, fbytes_in;
   logic [31:0]       fshift_ff, fshift_in;
   logic              is_insert_ff, is_insert_in;
   logic [31:0]       rec_len_ff, rec_len_in;
   logic [31:0]       tsize_ff, tsize_in;
   logic [32:0]       produced_ff, produced_in;
   logic [ADDR_W-1:0] copy_ptr_ff, copy_ptr_in;
   logic [31:0]       copy_rem_ff, copy_rem_in;
   logic [2:0]        error_ff, error_in;
   logic [16:0]       base_len_ff;

   logic [31:0]       gathered;
   logic              field_done;
   logic [32:0]       limit;
   logic [32:0]       copy_end;
   logic              emit;
   logic [2:0]        final_status;
   logic [XW-1:0]     load_addr;

   function automatic logic [2:0] keep_first(input logic [2:0] cur, input logic [2:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   assign gathered   = fshift_ff | (32'(item.byte_value) << {fbytes_ff, 3'b000});
   assign field_done = (fbytes_ff == 2'd3);
   assign limit      = (33'(base_len_ff) < DEPTH_33) ? 33'(base_len_ff) : DEPTH_33;
   assign copy_end   = {1'b0, gathered} + {1'b0, rec_len_ff};
   assign load_addr  = XW'(item.address);

   always_comb begin
      if (phase_ff == PH_MAGIC || phase_ff == PH_VERSION || phase_ff == PH_TSIZE ||
          phase_ff == PH_LENGTH || phase_ff == PH_OFFSET) begin
         final_status = ST_TRUNCATED;
      end else if (error_ff != ST_OK) begin
         final_status = error_ff;
      end else if (phase_ff == PH_INSERT) begin
         final_status = ST_TRUNCATED;
      end else if (phase_ff == PH_DRAIN) begin
         final_status = ST_MISUSE;
      end else if (produced_ff != {1'b0, tsize_ff}) begin
         final_status = ST_SIZE;
      end else begin
         final_status = ST_OK;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      fbytes_in    = fbytes_ff;
      fshift_in    = fshift_ff;
      is_insert_in = is_insert_ff;
      rec_len_in   = rec_len_ff;
      tsize_in     = tsize_ff;
      produced_in  = produced_ff;
      copy_ptr_in  = copy_ptr_ff;
      copy_rem_in  = copy_rem_ff;
      error_in     = error_ff;
      emit         = 1'b0;
      push         = 1'b0;
      push_entry   = '{op: OP_LITERAL, data: item.byte_value, status: ST_OK, count: '0};
      push_addr    = copy_ptr_ff;

      if (item_valid) begin
         unique case (item.command)
            CMD_LOAD: begin
               push_entry.op = OP_WRITE;
               push_addr     = load_addr[ADDR_W-1:0];
               push          = (32'(item.address) < 32'(BASE_DEPTH));
            end
            CMD_DELTA: begin
               // Field accumulation shared by every multi-byte field.
               fbytes_in = fbytes_ff + 2'd1;
               fshift_in = field_done ? 32'd0 : gathered;
               if (phase_ff == PH_DRAIN) begin
                  fbytes_in = fbytes_ff;
                  fshift_in = fshift_ff;
                  error_in  = keep_first(error_ff, ST_MISUSE);
               end else if (error_ff != ST_OK && !(phase_ff == PH_MAGIC ||
                            phase_ff == PH_VERSION || phase_ff == PH_TSIZE ||
                            phase_ff == PH_LENGTH)) begin
                  fbytes_in = fbytes_ff;
                  fshift_in = fshift_ff;
               end else begin
                  unique case (phase_ff)
                     PH_MAGIC: begin
                        if (item.byte_value != magic_byte(fbytes_ff)) begin
                           error_in = keep_first(error_ff, ST_BAD_MAGIC);
                        end
                        if (field_done) begin
                           phase_in = PH_VERSION;
                        end
                     end
                     PH_VERSION: begin
                        if (field_done) begin
                           if (gathered != 32'd1) begin
                              error_in = keep_first(error_ff, ST_BAD_VER);
                           end
                           phase_in = PH_TSIZE;
                        end
                     end
                     PH_TSIZE: begin
                        if (field_done) begin
                           tsize_in = gathered;
                           phase_in = PH_TYPE;
                        end
                     end
                     PH_TYPE: begin
                        fbytes_in = fbytes_ff;
                        fshift_in = fshift_ff;
                        if (item.byte_value > 8'd1) begin
                           error_in     = keep_first(error_ff, ST_BAD_TYPE);
                           is_insert_in = 1'b0;
                        end else begin
                           is_insert_in = item.byte_value[0];
                        end
                        phase_in = PH_LENGTH;
                     end
                     PH_LENGTH: begin
                        if (field_done) begin
                           rec_len_in = gathered;
                           if (error_ff != ST_OK) begin
                              phase_in = PH_TYPE;
                           end else if (is_insert_ff) begin
                              phase_in = (gathered != 32'd0) ? PH_INSERT : PH_TYPE;
                           end else begin
                              phase_in = PH_OFFSET;
                           end
                        end
                     end
                     PH_OFFSET: begin
                        if (field_done) begin
                           if (copy_end > limit) begin
                              error_in = keep_first(error_ff, ST_COPY_OOB);
                              phase_in = PH_TYPE;
                           end else if (rec_len_ff != 32'd0) begin
                              copy_ptr_in = gathered[ADDR_W-1:0];
                              copy_rem_in = rec_len_ff;
                              phase_in    = PH_DRAIN;
                           end else begin
                              phase_in = PH_TYPE;
                           end
                        end
                     end
                     PH_INSERT: begin
                        fbytes_in  = fbytes_ff;
                        fshift_in  = fshift_ff;
                        rec_len_in = rec_len_ff - 32'd1;
                        if (rec_len_ff == 32'd1) begin
                           phase_in = PH_TYPE;
                        end
                        push_entry.op = OP_LITERAL;
                        emit          = 1'b1;
                     end
                     PH_DRAIN: begin
                        fbytes_in = fbytes_ff;
                        fshift_in = fshift_ff;
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (phase_ff == PH_DRAIN && error_ff == ST_OK) begin
                  push_entry.op = OP_READ;
                  push_entry.data = '0;
                  push_addr     = copy_ptr_ff;
                  copy_ptr_in   = copy_ptr_ff + ADDR_W'(1);
                  copy_rem_in   = copy_rem_ff - 32'd1;
                  if (copy_rem_ff == 32'd1) begin
                     phase_in = PH_TYPE;
                  end
                  emit = 1'b1;
               end
            end
            CMD_FINISH: begin
               push_entry = '{op: OP_STATUS, data: '0, status: final_status,
                              count: produced_ff[32] ? 32'hFFFF_FFFF : produced_ff[31:0]};
               push         = 1'b1;
               phase_in     = PH_MAGIC;
               fbytes_in    = '0;
               fshift_in    = '0;
               is_insert_in = 1'b0;
               rec_len_in   = '0;
               tsize_in     = '0;
               produced_in  = '0;
               copy_ptr_in  = '0;
               copy_rem_in  = '0;
               error_in     = ST_OK;
            end
         endcase
         if (emit) begin
            push = 1'b1;
            if (produced_ff != COUNT_MAX) begin
               produced_in = produced_ff + 33'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         fbytes_ff    <= '0;
         fshift_ff    <= '0;
         is_insert_ff <= 1'b0;
         rec_len_ff   <= '0;
         tsize_ff     <= '0;
         produced_ff  <= '0;
         copy_ptr_ff  <= '0;
         copy_rem_ff  <= '0;
         error_ff     <= ST_OK;
         base_len_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         fbytes_ff    <= fbytes_in;
         fshift_ff    <= fshift_in;
         is_insert_ff <= is_insert_in;
         rec_len_ff   <= rec_len_in;
         tsize_ff     <= tsize_in;
         produced_ff  <= produced_in;
         copy_ptr_ff  <= copy_ptr_in;
         copy_rem_ff  <= copy_rem_in;
         error_ff     <= error_in;
         if (csr_write) begin
            base_len_ff <= csr_data;
         end
      end
   end

endmodule

// ===== sv/dpd_back.sv =====
// Back end of the delta patch decoder: drains the work queue in order, owns
// the base image RAM and the result register. Depends on dpd_pkg and dpd_ram.
`timescale 1ns / 1ps

module dpd_back
   import dpd_pkg::*;
#(
   parameter int BASE_DEPTH = 65536,
   parameter int ADDR_W     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  entry_type         q_entry,
   input  logic [ADDR_W-1:0] q_addr,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   logic       s1_valid_ff, s1_valid_in;
   entry_type  s1_entry_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       s1_move;
   logic       s1_ready;
   logic       ram_we;
   logic       ram_re;
   logic [7:0] ram_rd_data;

   // A stalled read keeps its data because the RAM is not read again until
   // the entry has moved on.
   assign s1_move  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_ready = !s1_valid_ff || s1_move;
   assign q_pop    = !q_empty && s1_ready;
   assign ram_we   = q_pop && (q_entry.op == OP_WRITE);
   assign ram_re   = q_pop && (q_entry.op == OP_READ);

   dpd_ram #(
      .WIDTH (8),
      .DEPTH (BASE_DEPTH)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_addr),
      .wr_data (q_entry.data),
      .rd_en   (ram_re),
      .rd_addr (q_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in  = (q_pop && q_entry.op != OP_WRITE) || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff <= q_entry;
      end
      if (s1_move) begin
         out_ff.is_status <= (s1_entry_ff.op == OP_STATUS);
         out_ff.out_byte  <= (s1_entry_ff.op == OP_READ) ? ram_rd_data : s1_entry_ff.data;
         out_ff.status    <= s1_entry_ff.status;
         out_ff.out_count <= s1_entry_ff.count;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== sv/delta_patch_decoder_core.sv =====
// Delta patch decoder top level: parser front end, four-entry work queue and
// back end with the base image RAM. Depends on dpd_pkg, dpd_front, dpd_queue,
// dpd_back and dpd_ram.
//
// The block takes one transaction per cycle (base loads, delta bytes, copy
// ticks and finish) and gives one result per cycle at most, through the queue,
// the back end's stage register and the output register. The back end makes one
// RAM access per cycle, so loads and copy reads sustain one per cycle unless
// the result side stalls. Input stalls only when the four-entry queue is full,
// which happens when the result side stalls. Base memory content is undefined
// until loaded; there is no clearing pass. The user must write base_length
// through the csr channel only while the block is idle; this is not enforced.
`timescale 1ns / 1ps

module delta_patch_decoder_core
   import dpd_pkg::*;
#(
   parameter int BASE_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   localparam int ADDR_W = $clog2(BASE_DEPTH);
   localparam int EW     = $bits(entry_type);
   localparam int QW     = EW + ADDR_W;

   logic              accept;
   logic              push;
   entry_type         push_entry;
   logic [ADDR_W-1:0] push_addr;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic [QW-1:0]     q_data;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   dpd_front #(
      .BASE_DEPTH (BASE_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (req_payload),
      .csr_write  (csr_valid),
      .csr_data   (csr_data),
      .push       (push),
      .push_entry (push_entry),
      .push_addr  (push_addr)
   );

   dpd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_entry, push_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   dpd_back #(
      .BASE_DEPTH (BASE_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_entry     (entry_type'(q_data[QW-1:ADDR_W])),
      .q_addr      (q_data[ADDR_W-1:0]),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
